/* design/prrt_pkg.sv */
// Shared types, codes and sizes of the pending request retry table.
// No dependencies; every other design file but prrt_ram refers to it by scoped names.
package prrt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] CMD_ISSUE    = 2'd0;
   localparam logic [1:0] CMD_RESPONSE = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;

   localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
   localparam logic [2:0] KIND_DUPLICATE = 3'd1;
   localparam logic [2:0] KIND_FULL      = 3'd2;
   localparam logic [2:0] KIND_MATCHED   = 3'd3;
   localparam logic [2:0] KIND_UNMATCHED = 3'd4;
   localparam logic [2:0] KIND_RESEND    = 3'd5;
   localparam logic [2:0] KIND_EXPIRED   = 3'd6;
   localparam logic [2:0] KIND_DONE      = 3'd7;

   localparam logic REG_TIMEOUT      = 1'b0;
   localparam logic REG_MAX_ATTEMPTS = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET      = 16'd10;
   localparam logic [2:0]  MAX_ATTEMPTS_RESET = 3'd4;

   typedef struct packed {
      logic [31:0] stamp;
      logic [2:0]  attempts;
      logic [15:0] id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [15:0] timeout_sec;
      logic [2:0]  max_attempts;
   } cfg_type;

   typedef struct packed {
      logic               rd_en;
      logic [IDX_W-1:0]   rd_addr;
      logic               wr_en;
      logic [IDX_W-1:0]   wr_addr;
      entry_type          wr_data;
   } ram_req_type;

endpackage

/* design/prrt_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module prrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* design/prrt_csr.sv */
// Configuration registers of the retry table behind an APB-style port.
// Depends on prrt_pkg for the register codes and the config struct.
module prrt_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output prrt_pkg::cfg_type    cfg
);

   logic [15:0] timeout_ff, timeout_in;
   logic [2:0]  max_att_ff, max_att_in;
   logic        wr_stb;

   assign csr_pready = 1'b1;
   assign wr_stb = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      timeout_in = timeout_ff;
      max_att_in = max_att_ff;
      if (wr_stb) begin
         unique case (csr_paddr[2])
            prrt_pkg::REG_TIMEOUT:      timeout_in = csr_pwdata[15:0];
            prrt_pkg::REG_MAX_ATTEMPTS: max_att_in = csr_pwdata[2:0];
            default:                    timeout_in = timeout_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         prrt_pkg::REG_TIMEOUT:      csr_prdata = {16'd0, timeout_ff};
         prrt_pkg::REG_MAX_ATTEMPTS: csr_prdata = {29'd0, max_att_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= prrt_pkg::TIMEOUT_RESET;
         max_att_ff <= prrt_pkg::MAX_ATTEMPTS_RESET;
      end else begin
         timeout_ff <= timeout_in;
         max_att_ff <= max_att_in;
      end
   end

   assign cfg.timeout_sec  = timeout_ff;
   assign cfg.max_attempts = max_att_ff;

endmodule

/* design/prrt_ctrl.sv */
// Sequencer of the retry table: lookup pass, report, compacting sweep, done.
// Depends on prrt_pkg; drives the table RAM through a ram_req_type struct.
module prrt_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  prrt_pkg::cfg_type                 cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_cmd,
   input  logic [15:0]                       req_id,
   input  logic [31:0]                       req_now,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [2:0]                        rsp_kind,
   output logic [15:0]                       rsp_id,
   output logic [2:0]                        rsp_attempt,
   output logic                              rsp_last,
   output prrt_pkg::ram_req_type             ram_req,
   input  prrt_pkg::entry_type               ram_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_REPORT,
      S_SWEEP,
      S_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [15:0]                 id_ff, id_in;
   logic [31:0]                 now_ff, now_in;
   logic [prrt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [prrt_pkg::CNT_W-1:0]  rptr_ff, rptr_in;
   logic [prrt_pkg::CNT_W-1:0]  wptr_ff, wptr_in;
   logic                        pend_ff, pend_in;
   logic                        hit_ff, hit_in;
   logic [2:0]                  hit_att_ff, hit_att_in;
   logic                        ovld_ff, ovld_in;
   logic [2:0]                  okind_ff, okind_in;
   logic [15:0]                 oid_ff, oid_in;
   logic [2:0]                  oatt_ff, oatt_in;
   logic                        olast_ff, olast_in;

   logic                        out_free;
   logic                        more;
   logic [31:0]                 age;
   logic                        timed_out;

   assign out_free  = !ovld_ff || rsp_ready;
   assign more      = rptr_ff < count_ff;
   assign age       = now_ff - ram_rd_data.stamp;
   assign timed_out = age >= {16'd0, cfg.timeout_sec};

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      id_in      = id_ff;
      now_in     = now_ff;
      count_in   = count_ff;
      rptr_in    = rptr_ff;
      wptr_in    = wptr_ff;
      pend_in    = pend_ff;
      hit_in     = hit_ff;
      hit_att_in = hit_att_ff;
      ovld_in    = ovld_ff && !rsp_ready;
      okind_in   = okind_ff;
      oid_in     = oid_ff;
      oatt_in    = oatt_ff;
      olast_in   = olast_ff;
      ram_req    = '0;
      ram_req.rd_addr = rptr_ff[prrt_pkg::IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            rptr_in = '0;
            wptr_in = '0;
            pend_in = 1'b0;
            hit_in  = 1'b0;
            if (req_valid) begin
               cmd_in = req_cmd;
               id_in  = req_id;
               now_in = req_now;
               unique case (req_cmd)
                  prrt_pkg::CMD_ISSUE,
                  prrt_pkg::CMD_RESPONSE: state_in = S_FIND;
                  prrt_pkg::CMD_TICK:     state_in = S_SWEEP;
                  default:                state_in = S_IDLE;
               endcase
            end
         end

         S_FIND: begin
            if (pend_ff && ram_rd_data.id == id_ff) begin
               hit_in     = 1'b1;
               hit_att_in = ram_rd_data.attempts;
               pend_in    = 1'b0;
               state_in   = S_REPORT;
            end else if (more) begin
               ram_req.rd_en = 1'b1;
               rptr_in = rptr_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_REPORT;
               end
            end
         end

         S_REPORT: begin
            if (out_free) begin
               ovld_in = 1'b1;
               oid_in  = id_ff;
               rptr_in = '0;
               wptr_in = '0;
               pend_in = 1'b0;
               if (cmd_ff == prrt_pkg::CMD_ISSUE) begin
                  olast_in = 1'b1;
                  state_in = S_IDLE;
                  oatt_in  = 3'd0;
                  if (hit_ff) begin
                     okind_in = prrt_pkg::KIND_DUPLICATE;
                  end else if (count_ff >= prrt_pkg::CNT_W'(prrt_pkg::TABLE_DEPTH)) begin
                     okind_in = prrt_pkg::KIND_FULL;
                  end else begin
                     okind_in = prrt_pkg::KIND_ACCEPTED;
                     oatt_in  = 3'd1;
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = count_ff[prrt_pkg::IDX_W-1:0];
                     ram_req.wr_data = '{stamp: now_ff, attempts: 3'd1, id: id_ff};
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  olast_in = 1'b0;
                  state_in = S_SWEEP;
                  okind_in = hit_ff ? prrt_pkg::KIND_MATCHED : prrt_pkg::KIND_UNMATCHED;
                  oatt_in  = hit_ff ? hit_att_ff : 3'd0;
               end
            end
         end

         S_SWEEP: begin
            if (out_free) begin
               if (pend_ff) begin
                  if (hit_ff && ram_rd_data.id == id_ff) begin
                     // matched entry leaves the table: no write-back
                  end else if (timed_out && ram_rd_data.attempts >= cfg.max_attempts) begin
                     ovld_in  = 1'b1;
                     okind_in = prrt_pkg::KIND_EXPIRED;
                     oid_in   = ram_rd_data.id;
                     oatt_in  = ram_rd_data.attempts;
                     olast_in = 1'b0;
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = wptr_ff[prrt_pkg::IDX_W-1:0];
                     ram_req.wr_data = ram_rd_data;
                     wptr_in = wptr_ff + 1'b1;
                     if (timed_out) begin
                        ram_req.wr_data.attempts = ram_rd_data.attempts + 3'd1;
                        ram_req.wr_data.stamp    = now_ff;
                        ovld_in  = 1'b1;
                        okind_in = prrt_pkg::KIND_RESEND;
                        oid_in   = ram_rd_data.id;
                        oatt_in  = ram_rd_data.attempts + 3'd1;
                        olast_in = 1'b0;
                     end
                  end
               end
               if (more) begin
                  ram_req.rd_en = 1'b1;
                  rptr_in = rptr_ff + 1'b1;
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
                  if (!pend_ff) begin
                     count_in = wptr_ff;
                     state_in = S_DONE;
                  end
               end
            end
         end

         S_DONE: begin
            if (out_free) begin
               ovld_in  = 1'b1;
               okind_in = prrt_pkg::KIND_DONE;
               oid_in   = 16'd0;
               oatt_in  = 3'd0;
               olast_in = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         ovld_ff  <= 1'b0;
         rptr_ff  <= '0;
         wptr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         hit_ff   <= hit_in;
         ovld_ff  <= ovld_in;
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
      end
      cmd_ff     <= cmd_in;
      id_ff      <= id_in;
      now_ff     <= now_in;
      hit_att_ff <= hit_att_in;
      okind_ff   <= okind_in;
      oid_ff     <= oid_in;
      oatt_ff    <= oatt_in;
      olast_ff   <= olast_in;
   end

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = ovld_ff;
   assign rsp_kind    = okind_ff;
   assign rsp_id      = oid_ff;
   assign rsp_attempt = oatt_ff;
   assign rsp_last    = olast_ff;

endmodule

/* design/pending_request_retry_table.sv */
// Top level of the pending request retry table: stream ports, APB registers.
// Depends on prrt_pkg, prrt_ram, prrt_csr and prrt_ctrl.
//
//   channel   direction  handshake              payload
//   req_*     in         req_tvalid/req_tready  tuser cmd, tdata id + now_sec
//   rsp_*     out        rsp_tvalid/rsp_tready  tuser kind, tdata id + attempt, tlast
//   csr_*     in         psel/penable/pready    timeout_sec @0x0, max_attempts @0x4
//
// One request at a time; the table sits in a single RAM with one read port,
// so every pass walks it at one entry per cycle, a sweep only while its results are taken.
// Issue: lookup pass then report. Tick: sweep, done. Response: lookup,
// report, sweep, done. The sweep rewrites surviving entries downward, so
// removals cost no extra pass. A stalled result holds the sequencer in
// place until it is taken. Reset empties the table at once (count cleared)
// and loads the register defaults; RAM contents need no clearing.
module pending_request_retry_table (
   input  logic        clock,
   input  logic        reset,
   // request in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] req_id, [47:16] now_sec
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // result out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] out_id, [18:16] attempt, [23:19] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   prrt_pkg::cfg_type      cfg;
   prrt_pkg::ram_req_type  ram_req;
   prrt_pkg::entry_type    ram_rd_data;
   logic [15:0]            rsp_id;
   logic [2:0]             rsp_attempt;

   // hold the register file
   prrt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // hold the table entries: id, attempt count, send stamp
   prrt_ram #(
      .WIDTH (prrt_pkg::ENTRY_W),
      .DEPTH (prrt_pkg::TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // advance lookups and sweeps, one entry per cycle while no result stalls
   prrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_id      (req_tdata[15:0]),
      .req_now     (req_tdata[47:16]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_id      (rsp_id),
      .rsp_attempt (rsp_attempt),
      .rsp_last    (rsp_tlast),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data)
   );

   assign rsp_tdata = {5'd0, rsp_attempt, rsp_id};

endmodule

/* tb/testbench.sv */
// Self-checking bench for pending_request_retry_table: issue, response and tick requests
// on the stream input, results checked against an in-bench shadow of the retry table.
// Depends on prrt_pkg and the pending_request_retry_table design files.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import prrt_pkg::*;

   // Command code three is not a real command: the block drops it without a result.
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [2:0] ADDR_TIMEOUT      = {REG_TIMEOUT, 2'b00};
   localparam logic [2:0] ADDR_MAX_ATTEMPTS = {REG_MAX_ATTEMPTS, 2'b00};

   // A response walks the table twice plus a few steps; allow that much quiet time
   // after the last result before touching the registers or ending the run.
   localparam int LATENCY_PAUSE  = 2 * TABLE_DEPTH + 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 50;
   localparam int PHASES         = 4;
   localparam int unsigned PHASE_TIMEOUT [PHASES] = '{3, 1, 65535, 6};
   localparam int unsigned PHASE_MAX_ATT [PHASES] = '{3, 7, 2, 1};

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] id;
      logic [2:0]  attempt;
      logic        last;
   } outcome_t;

   typedef enum logic {ROW_SEND, ROW_SET} row_kind_e;

   // One directed step: either a request (repeated reps times with the id counting
   // up) or a register write, whose value rides in the now field.
   typedef struct packed {
      row_kind_e   what;
      logic [1:0]  cmd;
      logic [15:0] id;
      logic [31:0] now;
      logic [4:0]  reps;
      logic [2:0]  addr;
      logic        chk;
      outcome_t    first;
   } plan_row_t;

   localparam int PLAN_ROWS = 17;
   localparam plan_row_t DIRECTED [PLAN_ROWS] = '{
      // empty table right after reset: a tick only closes its sweep
      '{ROW_SEND, CMD_TICK,     16'h0000, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_DONE, 16'h0000, 3'd0, 1'b1}},
      '{ROW_SEND, CMD_RESPONSE, 16'h1234, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_UNMATCHED, 16'h1234, 3'd0, 1'b0}},
      '{ROW_SEND, CMD_ISSUE,    16'h0000, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_ACCEPTED, 16'h0000, 3'd1, 1'b1}},
      '{ROW_SEND, CMD_ISSUE,    16'hFFFF, 32'hFFFF_FFFF, 5'd1, 3'd0, 1'b1,
        '{KIND_ACCEPTED, 16'hFFFF, 3'd1, 1'b1}},
      '{ROW_SEND, CMD_ISSUE,    16'h0000, 32'h0000_0005, 5'd1, 3'd0, 1'b1,
        '{KIND_DUPLICATE, 16'h0000, 3'd0, 1'b1}},
      '{ROW_SEND, CMD_NONE,     16'hAAAA, 32'h5555_5555, 5'd1, 3'd0, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      // age of the 0xFFFF entry wraps through zero and lands exactly on the timeout
      '{ROW_SEND, CMD_TICK,     16'h5555, 32'h0000_0009, 5'd1, 3'd0, 1'b1,
        '{KIND_RESEND, 16'hFFFF, 3'd2, 1'b0}},
      '{ROW_SEND, CMD_RESPONSE, 16'h0000, 32'h0000_000A, 5'd1, 3'd0, 1'b1,
        '{KIND_MATCHED, 16'h0000, 3'd1, 1'b0}},
      // fill the table, then knock on it once more
      '{ROW_SEND, CMD_ISSUE,    16'h0100, 32'hAAAA_AAAA, 5'd15, 3'd0, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      '{ROW_SEND, CMD_ISSUE,    16'h7777, 32'hAAAA_AAAA, 5'd1, 3'd0, 1'b1,
        '{KIND_FULL, 16'h7777, 3'd0, 1'b1}},
      // zero timeout: every entry is due on every sweep
      '{ROW_SET,  CMD_ISSUE,    16'h0000, 32'h0000_0000, 5'd1, ADDR_TIMEOUT, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      '{ROW_SEND, CMD_TICK,     16'h0000, 32'h1234_5678, 5'd1, 3'd0, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      // lower the limit to at most the pending counts, then sweep a full table
      '{ROW_SET,  CMD_ISSUE,    16'h0000, 32'h0000_0002, 5'd1, ADDR_MAX_ATTEMPTS, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      '{ROW_SEND, CMD_RESPONSE, 16'h4242, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_UNMATCHED, 16'h4242, 3'd0, 1'b0}},
      // zero limit: a due entry expires on its first timeout
      '{ROW_SET,  CMD_ISSUE,    16'h0000, 32'h0000_0000, 5'd1, ADDR_MAX_ATTEMPTS, 1'b0,
        '{3'd0, 16'h0000, 3'd0, 1'b0}},
      '{ROW_SEND, CMD_ISSUE,    16'h8001, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_ACCEPTED, 16'h8001, 3'd1, 1'b1}},
      '{ROW_SEND, CMD_TICK,     16'h0000, 32'h0000_0000, 5'd1, 3'd0, 1'b1,
        '{KIND_EXPIRED, 16'h8001, 3'd1, 1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // [15:0] req_id, [47:16] now_sec
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] out_id, [18:16] attempt, [23:19] zero
   logic [2:0]  rsp_tuser;        // [2:0] kind
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the retry table and its registers.
   logic [15:0] shadow_id    [TABLE_DEPTH];
   logic [2:0]  shadow_att   [TABLE_DEPTH];
   logic [31:0] shadow_stamp [TABLE_DEPTH];
   int          shadow_count = 0;
   logic [15:0] shadow_timeout = TIMEOUT_RESET;
   logic [2:0]  shadow_max_att = MAX_ATTEMPTS_RESET;

   outcome_t    outcome_q [$];
   logic        override_pending = 1'b0;
   outcome_t    override_val;

   int unsigned error_count = 0;
   int          quiet_cycles = 0;
   int          send_calm = 0;
   int          rsp_calm = 0;
   int          rsp_stall = 0;
   int          rsp_roll;

   pending_request_retry_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Queue one predicted result; a typed-in directed value takes the place of the
   // first result of its request.
   function void queue_outcome(input logic [2:0] kind, input logic [15:0] id,
                               input logic [2:0] att, input logic last);
      outcome_t o;
      o = '{kind, id, att, last};
      if (override_pending) begin
         o = override_val;
         override_pending = 1'b0;
      end
      outcome_q.push_back(o);
   endfunction

   // Remove one entry and close the gap, keeping insertion order.
   function void drop_entry(input int pos);
      for (int j = pos; j + 1 < shadow_count; j++) begin
         shadow_id[j]    = shadow_id[j + 1];
         shadow_att[j]   = shadow_att[j + 1];
         shadow_stamp[j] = shadow_stamp[j + 1];
      end
      shadow_count--;
   endfunction

   // Apply one accepted request to the shadow table and queue the results it causes.
   task automatic track_request(input logic [1:0] cmd, input logic [15:0] id,
                                input logic [31:0] now);
      int          pos;
      int          i;
      logic [31:0] age;
      pos = -1;
      if (cmd == CMD_NONE)
         return;
      for (i = 0; i < shadow_count; i++)
         if (pos < 0 && shadow_id[i] == id)
            pos = i;
      if (cmd == CMD_ISSUE) begin
         if (pos >= 0) begin
            queue_outcome(KIND_DUPLICATE, id, 3'd0, 1'b1);
         end else if (shadow_count >= TABLE_DEPTH) begin
            queue_outcome(KIND_FULL, id, 3'd0, 1'b1);
         end else begin
            shadow_id[shadow_count]    = id;
            shadow_att[shadow_count]   = 3'd1;
            shadow_stamp[shadow_count] = now;
            shadow_count++;
            queue_outcome(KIND_ACCEPTED, id, 3'd1, 1'b1);
         end
         return;
      end
      if (cmd == CMD_RESPONSE) begin
         if (pos >= 0) begin
            queue_outcome(KIND_MATCHED, id, shadow_att[pos], 1'b0);
            drop_entry(pos);
         end else begin
            queue_outcome(KIND_UNMATCHED, id, 3'd0, 1'b0);
         end
      end
      // Sweep in order; an expired entry pulls the next one into its slot.
      i = 0;
      while (i < shadow_count) begin
         age = now - shadow_stamp[i];
         if (age >= {16'd0, shadow_timeout}) begin
            if (shadow_att[i] >= shadow_max_att) begin
               queue_outcome(KIND_EXPIRED, shadow_id[i], shadow_att[i], 1'b0);
               drop_entry(i);
               continue;
            end
            shadow_att[i]   = shadow_att[i] + 3'd1;
            shadow_stamp[i] = now;
            queue_outcome(KIND_RESEND, shadow_id[i], shadow_att[i], 1'b0);
         end
         i++;
      end
      queue_outcome(KIND_DONE, 16'h0000, 3'd0, 1'b1);
   endtask

   // Sender gaps: mostly none or short, a few long, and calm stretches with none.
   function int pick_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         send_calm = $urandom_range(10, 30);
         return 0;
      end
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Present one request at the falling edge and hold it until the block takes it.
   task automatic send_request(input logic [1:0] cmd, input logic [15:0] id,
                               input logic [31:0] now, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {now, id};
      do @(posedge clock); while (!req_tready);
      track_request(cmd, id, now);
   endtask

   // Drop the request line, then hold until every predicted result has been delivered.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr,
                             input logic [31:0] data, output logic [31:0] rd);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write a register once the block is idle, mirror it, and read it back.
   task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
      logic [31:0] rd;
      logic [31:0] want;
      settle();
      repeat (LATENCY_PAUSE) @(posedge clock);
      csr_access(1'b1, addr, value, rd);
      if (addr == ADDR_TIMEOUT) begin
         shadow_timeout = value[15:0];
         want = {16'd0, value[15:0]};
      end else begin
         shadow_max_att = value[2:0];
         want = {29'd0, value[2:0]};
      end
      csr_access(1'b0, addr, 32'd0, rd);
      if (rd !== want) begin
         $error("register 0x%0h readback: expected 0x%0h, got 0x%0h", addr, want, rd);
         error_count++;
      end
   endtask

   // Receiver: random stalls, mostly short, a few long, with calm stretches.
   always @(negedge clock) begin
      if (rsp_calm > 0) begin
         rsp_calm--;
         rsp_tready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 3)
            rsp_calm = $urandom_range(20, 80);
         else if (rsp_roll < 8)
            rsp_stall = $urandom_range(10, 30);
         else if (rsp_roll < 30)
            rsp_stall = $urandom_range(1, 3);
         rsp_tready <= (rsp_stall == 0);
      end
   end

   // Check each delivered result against the oldest prediction.
   always @(posedge clock) begin
      outcome_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected result: kind %0d out_id 0x%0h", rsp_tuser, rsp_tdata[15:0]);
            error_count++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[15:0] !== want.id) begin
               $error("out_id: expected 0x%0h, got 0x%0h", want.id, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[18:16] !== want.attempt) begin
               $error("attempt: expected %0d, got %0d", want.attempt, rsp_tdata[18:16]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      plan_row_t   row;
      int          sent;
      int unsigned adv;
      logic [31:0] tb_now;
      logic [15:0] pool_base;
      logic [15:0] id;
      logic [1:0]  cmd;
      int          roll;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the table; typed rows pin the first result.
      for (int k = 0; k < PLAN_ROWS; k++) begin
         row = DIRECTED[k];
         if (row.what == ROW_SET) begin
            write_register(row.addr, row.now);
         end else begin
            for (int n = 0; n < row.reps; n++) begin
               override_pending = row.chk;
               override_val     = row.first;
               send_request(row.cmd, row.id + 16'(n), row.now, pick_gap());
            end
         end
      end

      // Random part: one register setting per phase, a small id pool so that
      // duplicates, matches and a full table come up, and time that advances in
      // steps scaled to the timeout so entries resend and expire.
      for (int p = 0; p < PHASES; p++) begin
         write_register(ADDR_TIMEOUT, PHASE_TIMEOUT[p]);
         write_register(ADDR_MAX_ATTEMPTS, PHASE_MAX_ATT[p]);
         tb_now    = (p == 0) ? 32'hFFFF_FFC0 : $urandom;
         pool_base = 16'($urandom_range(0, 65535));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (shadow_timeout == 16'hFFFF)
               adv = $urandom_range(0, 30000);
            else
               adv = $urandom_range(0, shadow_timeout / 2 + 1);
            if ($urandom_range(0, 11) == 0)
               adv = $urandom_range(0, 3 * int'(shadow_timeout));
            if ($urandom_range(0, 19) == 0)
               tb_now = $urandom;
            else
               tb_now = tb_now + adv;

            roll = $urandom_range(0, 99);
            if (roll < 40)
               cmd = CMD_ISSUE;
            else if (roll < 65)
               cmd = CMD_RESPONSE;
            else if (roll < 95)
               cmd = CMD_TICK;
            else
               cmd = CMD_NONE;

            if (cmd == CMD_RESPONSE && shadow_count > 0 && $urandom_range(0, 9) < 7)
               id = shadow_id[$urandom_range(0, shadow_count - 1)];
            else if (cmd == CMD_TICK || cmd == CMD_NONE || $urandom_range(0, 7) == 0)
               id = 16'($urandom);
            else
               id = pool_base + 16'($urandom_range(0, 19));

            send_request(cmd, id, tb_now, pick_gap());
            if (cmd != CMD_NONE) begin
               sent++;
               // Hold the sender once per phase until the block has drained.
               if (sent == PHASE_ITEMS / 2)
                  settle();
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      settle();
      repeat (LATENCY_PAUSE) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* files.f */
design/prrt_pkg.sv
design/prrt_ram.sv
design/prrt_csr.sv
design/prrt_ctrl.sv
design/pending_request_retry_table.sv
tb/testbench.sv
